/* design/bhcc_pkg.sv */
// bhcc_pkg: shared types and constants for the blob header crc-32 checker
// no dependencies; imported by bhcc_crc8 and blob_header_crc32_checker_unit
`default_nettype none

package bhcc_pkg;

    // header layout and crc-32 constants
    localparam int unsigned HEADER_BYTES = 28;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MAGIC   = 1'b0,
        REG_VERSION = 1'b1
    } t_reg_idx;

    // result status codes, checked in this order
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_VERSION  = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_CHECKSUM = 3'd5
    } t_status;

endpackage

`default_nettype wire

/* design/bhcc_crc8.sv */
// bhcc_crc8: one-byte update of the reflected crc-32 register
// depends on bhcc_pkg for the polynomial
`default_nettype none

module bhcc_crc8
    import bhcc_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        // eight shift steps flatten into a plain xor network
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

/* design/blob_header_crc32_checker_unit.sv */
// channel  dir  tdata fields (lsb first)                          tlast      tuser
// s_axis   in   blob_byte[7:0]                                    last_byte  -
// m_axis   out  status, computed_crc, stored_crc, payload_size,   -          -
//               header_version, 5 zero pad bits
// cfg      in   i_cfg_idx selects expected_magic / newest_version, i_cfg_data value
//
// one byte per cycle sustained: a byte is registered at the input, then the
// header capture, crc byte update and status checks run while it sits in the
// input register, and the status lands in the output register on the final byte.
// a stalled result only blocks a final byte; header and payload bytes keep
// flowing. synchronous active-low reset clears control and per-blob state.
// depends on bhcc_pkg and bhcc_crc8
`default_nettype none

module blob_header_crc32_checker_unit
    import bhcc_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    // byte stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] blob_byte
    input  logic         s_axis_tlast,   // last_byte
    // status out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [34:3] computed_crc, [66:35] stored_crc,
    // [98:67] payload_size, [130:99] header_version, [135:131] zero
    output logic [135:0] m_axis_tdata
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [2:0] WORD_MAGIC    = 3'd0;
    localparam logic [2:0] WORD_VERSION  = 3'd1;
    localparam logic [2:0] WORD_SIZE     = 3'd3;
    localparam logic [2:0] WORD_CHECKSUM = 3'd5;

    // configuration
    logic [31:0] r_expected_magic;
    logic [31:0] r_newest_version;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic <= '0;
            r_newest_version <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MAGIC:   r_expected_magic <= i_cfg_data;
                REG_VERSION: r_newest_version <= i_cfg_data;
                default:     r_expected_magic <= r_expected_magic;
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       out_free;
    logic       proc;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    // only a final byte needs room in the output register
    assign proc          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // per-blob state
    logic [COUNT_BITS-1:0] r_byte_count, n_byte_count;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_magic, n_magic;
    logic [31:0] r_version, n_version;
    logic [31:0] r_size, n_size;
    logic [31:0] r_checksum, n_checksum;
    logic [31:0] crc_upd;
    logic [31:0] lane_bits;
    logic        in_header;
    logic [32:0] expect_len;
    logic [31:0] crc_final;
    t_status     n_status;

    bhcc_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_byte (r_in_byte),
        .o_crc  (crc_upd)
    );

    assign in_header = r_byte_count < COUNT_BITS'(HEADER_BYTES);
    assign lane_bits = {24'd0, r_in_byte} << {r_byte_count[1:0], 3'b000};

    always_comb begin
        n_magic    = r_magic;
        n_version  = r_version;
        n_size     = r_size;
        n_checksum = r_checksum;
        n_crc      = r_crc;
        if (in_header) begin
            case (r_byte_count[4:2])
                WORD_MAGIC:    n_magic    = r_magic | lane_bits;
                WORD_VERSION:  n_version  = r_version | lane_bits;
                WORD_SIZE:     n_size     = r_size | lane_bits;
                WORD_CHECKSUM: n_checksum = r_checksum | lane_bits;
                default:       n_magic    = r_magic;
            endcase
        end else begin
            n_crc = crc_upd;
        end
        n_byte_count = (r_byte_count == COUNT_MAX) ? r_byte_count
                                                   : r_byte_count + 1'b1;
    end

    assign expect_len = 33'(HEADER_BYTES) + {1'b0, n_size};
    assign crc_final  = n_crc ^ CRC_ONES;

    always_comb begin
        if (n_byte_count < COUNT_BITS'(HEADER_BYTES)) begin
            n_status = ST_SHORT;
        end else if (n_magic != r_expected_magic) begin
            n_status = ST_MAGIC;
        end else if (n_version > r_newest_version) begin
            n_status = ST_VERSION;
        end else if (n_byte_count == COUNT_MAX ||
                     33'(n_byte_count) != expect_len) begin
            n_status = ST_LENGTH;
        end else if (crc_final != n_checksum) begin
            n_status = ST_CHECKSUM;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= CRC_ONES;
            r_magic      <= '0;
            r_version    <= '0;
            r_size       <= '0;
            r_checksum   <= '0;
        end else if (proc) begin
            if (r_in_last) begin
                // blob done, start the next one clean
                r_byte_count <= '0;
                r_crc        <= CRC_ONES;
                r_magic      <= '0;
                r_version    <= '0;
                r_size       <= '0;
                r_checksum   <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_crc        <= n_crc;
                r_magic      <= n_magic;
                r_version    <= n_version;
                r_size       <= n_size;
                r_checksum   <= n_checksum;
            end
        end
    end

    // output register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [31:0] r_out_crc;
    logic [31:0] r_out_stored;
    logic [31:0] r_out_size;
    logic [31:0] r_out_version;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_out_status  <= n_status;
            // no payload byte means the crc reads as zero
            r_out_crc     <= crc_final;
            r_out_stored  <= n_checksum;
            r_out_size    <= n_size;
            r_out_version <= n_version;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_version, r_out_size, r_out_stored,
                            r_out_crc, r_out_status};

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> r_byte_count == '0 && r_crc == CRC_ONES)
        else $error("per-blob state not cleared after final byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && !r_in_last && r_byte_count != COUNT_MAX
        |=> r_byte_count == $past(r_byte_count) + 1'b1)
        else $error("byte count did not advance");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proc && r_in_last))
        else $error("result appeared without a final byte");

    a_ok_means_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_OK |-> r_out_crc == r_out_stored)
        else $error("ok status with mismatching checksum");

    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && !out_free |=> r_in_valid && r_in_last)
        else $error("final byte dropped while result stalled");
`endif

endmodule

`default_nettype wire
